### hdl/dsc_pkg.sv
// shared types and constants for the direct state count block
package dsc_pkg;

  localparam int unsigned OP_W       = 2;
  localparam int unsigned BIN_W      = 12;
  localparam int unsigned VAL_W      = 56;
  localparam int unsigned FREQ_W     = 20;
  localparam int unsigned GSIZE_W    = 16;
  localparam int unsigned GRECIP_W   = 32;
  localparam int unsigned GCOUNT_W   = 13;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [VAL_W-1:0] VAL_MAX = {VAL_W{1'b1}};

  // rounding divider: (2f + g) / (2g)
  localparam int unsigned DIV_NUM_W = 22;
  localparam int unsigned DIV_DEN_W = GSIZE_W + 1;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_NUM_W);

  // density scaling, value split in two halves times the Q8.24 reciprocal
  localparam int unsigned HALF_W    = 28;
  localparam int unsigned PROD_W    = HALF_W + GRECIP_W;
  localparam int unsigned RECIP_FRAC = 24;

  typedef enum logic [OP_W-1:0] {
    OP_INIT = 2'd0,
    OP_LOAD = 2'd1,
    OP_ADD  = 2'd2,
    OP_READ = 2'd3
  } dsc_op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SUM_MODE    = 2'd0,
    CFG_GRAIN_SIZE  = 2'd1,
    CFG_GRAIN_RECIP = 2'd2,
    CFG_GRAIN_COUNT = 2'd3
  } dsc_cfg_e;

  typedef struct packed {
    logic done;
    logic sat;
  } dsc_scl_sts_t;

endpackage

### hdl/dsc_if.sv
// item channels: oscillator/table commands in, bin counts out
interface dsc_in_if;
  import dsc_pkg::*;
  logic                valid;
  logic                ready;
  logic [OP_W-1:0]     operation;
  logic [BIN_W-1:0]    bin_index;
  logic [VAL_W-1:0]    load_value;
  logic [FREQ_W-1:0]   frequency;

  modport source (output valid, operation, bin_index, load_value, frequency, input ready);
  modport sink   (input valid, operation, bin_index, load_value, frequency, output ready);
endinterface

interface dsc_out_if;
  import dsc_pkg::*;
  logic              valid;
  logic              ready;
  logic [VAL_W-1:0]  count_value;
  logic              overflowed;

  modport source (output valid, count_value, overflowed, input ready);
  modport sink   (input valid, count_value, overflowed, output ready);
endinterface

### hdl/dsc_divider.sv
// restoring divider, one quotient bit per cycle, gives the grain shift
module dsc_divider (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [dsc_pkg::DIV_NUM_W-1:0]  numer_i,
  input  logic [dsc_pkg::DIV_DEN_W-1:0]  denom_i,
  output logic                           done_o,
  output logic [dsc_pkg::DIV_NUM_W-1:0]  quotient_o
);
  import dsc_pkg::*;

  logic                 busy_q, done_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [DIV_NUM_W-1:0] quo_q;
  logic [DIV_DEN_W-1:0] rem_q, den_q;
  logic [DIV_DEN_W:0]   rem_sh, rem_sub;
  logic                 ge;

  always_comb begin
    rem_sh  = {rem_q, quo_q[DIV_NUM_W-1]};
    ge      = rem_sh >= {1'b0, den_q};
    rem_sub = rem_sh - {1'b0, den_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      quo_q  <= '0;
      rem_q  <= '0;
      den_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
        quo_q  <= numer_i;
        rem_q  <= '0;
        den_q  <= denom_i;
      end else if (busy_q) begin
        quo_q <= {quo_q[DIV_NUM_W-2:0], ge};
        rem_q <= ge ? rem_sub[DIV_DEN_W-1:0] : rem_sh[DIV_DEN_W-1:0];
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == DIV_CNT_W'(DIV_NUM_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

### hdl/dsc_scaler.sv
// density readout scaling: one 28x32 multiplier used for both halves
module dsc_scaler (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [dsc_pkg::VAL_W-1:0]     value_i,
  input  logic [dsc_pkg::GRECIP_W-1:0]  recip_i,
  output dsc_pkg::dsc_scl_sts_t         sts_o,
  output logic [dsc_pkg::VAL_W-1:0]     result_o
);
  import dsc_pkg::*;

  logic                ph1_q, ph2_q, done_q, sat_q;
  logic [HALF_W-1:0]   lo_q, mul_a;
  logic [PROD_W-1:0]   product_q, hi_q;
  logic [VAL_W-1:0]    result_q;
  logic [PROD_W:0]     rounded;
  logic [VAL_W:0]      total;
  logic                hi_big;

  always_comb begin
    mul_a   = ph1_q ? lo_q : value_i[VAL_W-1:VAL_W-HALF_W];
    hi_big  = hi_q > PROD_W'(VAL_MAX >> 4);
    rounded = {1'b0, product_q} + (PROD_W+1)'(1 << (RECIP_FRAC - 1));
    total   = (VAL_W+1)'({hi_q[VAL_W-5:0], 4'b0000})
            + (VAL_W+1)'(rounded[PROD_W:RECIP_FRAC]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph1_q     <= 1'b0;
      ph2_q     <= 1'b0;
      done_q    <= 1'b0;
      sat_q     <= 1'b0;
      lo_q      <= '0;
      product_q <= '0;
      hi_q      <= '0;
      result_q  <= '0;
    end else begin
      ph1_q     <= start_i;
      ph2_q     <= ph1_q;
      done_q    <= ph2_q;
      product_q <= PROD_W'(mul_a) * PROD_W'(recip_i);
      if (start_i) begin
        lo_q <= value_i[HALF_W-1:0];
      end
      if (ph1_q) begin
        hi_q <= product_q;
      end
      if (ph2_q) begin
        sat_q    <= hi_big | total[VAL_W];
        result_q <= (hi_big | total[VAL_W]) ? VAL_MAX : total[VAL_W-1:0];
      end
    end
  end

  assign sts_o.done = done_q;
  assign sts_o.sat  = sat_q;
  assign result_o   = result_q;

endmodule

### hdl/dsc_table.sv
// count table memory: one write port, two registered read ports
module dsc_table #(
  parameter  int unsigned Depth = 4096,
  localparam int unsigned IdxW  = $clog2(Depth)
) (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [IdxW-1:0]            waddr_i,
  input  logic [dsc_pkg::VAL_W-1:0]  wdata_i,
  input  logic [IdxW-1:0]            raddr_a_i,
  input  logic [IdxW-1:0]            raddr_b_i,
  output logic [dsc_pkg::VAL_W-1:0]  rdata_a_o,
  output logic [dsc_pkg::VAL_W-1:0]  rdata_b_o
);
  import dsc_pkg::*;

  logic [VAL_W-1:0] mem_q [Depth];
  logic [VAL_W-1:0] rdata_a_q, rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_q <= mem_q[raddr_a_i];
    rdata_b_q <= mem_q[raddr_b_i];
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

### hdl/direct_state_count.sv
// top level: direct count of states over an energy grain table
//
//   channel  dir  handshake     contents
//   in_i     in   valid/ready   operation, bin_index, load_value, frequency
//   out_o    out  valid/ready   count_value, overflowed (read only)
//   cfg      in   cfg_we_i      cfg_index_i, cfg_data_i
//
// after reset a clearing pass writes every bin, no items taken
// initialise: one table write per cycle
// load: one table write; read: ST_READ, ST_SCALE (density mode, shared multiplier), ST_PUSH
// add oscillator: divider, then, when shift < n, one bin per cycle through the shared
// saturating adder and the dual-read table
// a read result waits in the output register; a stalled output holds a later read
module direct_state_count #(
  parameter int unsigned MAX_BINS      = 4096,
  parameter int unsigned FRACTION_BITS = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [dsc_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [dsc_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  dsc_in_if.sink                          in_i,
  dsc_out_if.source                       out_o
);
  import dsc_pkg::*;

  localparam int unsigned IdxW = $clog2(MAX_BINS);
  localparam int unsigned CntW = $clog2(MAX_BINS + 1);
  localparam int unsigned NW   = (CntW > GCOUNT_W) ? CntW : GCOUNT_W;
  localparam logic [IdxW-1:0]  FILL_LAST = IdxW'(MAX_BINS - 1);
  localparam logic [VAL_W-1:0] ONE_VALUE = VAL_W'(1) << FRACTION_BITS;

  typedef enum logic [2:0] {
    ST_FILL, ST_IDLE, ST_DIV, ST_SWEEP, ST_READ, ST_SCALE, ST_PUSH
  } state_e;

  // configuration
  logic                 sum_mode_q;
  logic [GSIZE_W-1:0]   grain_size_q;
  logic [GRECIP_W-1:0]  grain_recip_q;
  logic [GCOUNT_W-1:0]  grain_count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_mode_q    <= 1'b1;
      grain_size_q  <= GSIZE_W'(16);
      grain_recip_q <= GRECIP_W'(32'd16777216);
      grain_count_q <= GCOUNT_W'(4096);
    end else if (cfg_we_i) begin
      unique case (dsc_cfg_e'(cfg_index_i))
        CFG_SUM_MODE:    sum_mode_q    <= cfg_data_i[0];
        CFG_GRAIN_SIZE:  grain_size_q  <= cfg_data_i[GSIZE_W-1:0];
        CFG_GRAIN_RECIP: grain_recip_q <= cfg_data_i[GRECIP_W-1:0];
        CFG_GRAIN_COUNT: grain_count_q <= cfg_data_i[GCOUNT_W-1:0];
        default: ;
      endcase
    end
  end

  state_e              state_q;
  logic [IdxW-1:0]     fill_q;
  logic                fill_init_q;
  logic                ovf_flag_q;
  logic                rd_inrange_q;
  logic [NW-1:0]       issue_q, shift_q;
  logic                stg_v_q, fwd_q;
  logic [IdxW-1:0]     stg_idx_q;
  logic [VAL_W-1:0]    last_q, res_q;
  logic                out_valid_q, out_ovf_q;
  logic [VAL_W-1:0]    out_count_q;

  logic [NW-1:0]       n_bins, idx_ext, issue_diff;
  logic                in_fire, idx_ok, shift_one;
  dsc_op_e             op;

  logic                mem_we;
  logic [IdxW-1:0]     mem_waddr, raddr_a, raddr_b;
  logic [VAL_W-1:0]    mem_wdata, rdata_a, rdata_b, add_b, stg_wdata;
  logic [VAL_W:0]      stg_sum;
  logic                stg_sat;

  logic [GSIZE_W-1:0]   g_eff;
  logic [DIV_NUM_W-1:0] div_num, div_quo;
  logic [DIV_DEN_W-1:0] div_den;
  logic                 div_start, div_done;

  logic                 scl_start;
  dsc_scl_sts_t         scl_sts;
  logic [VAL_W-1:0]     scl_result;

  always_comb begin
    if (grain_count_q == '0) begin
      n_bins = NW'(1);
    end else if (NW'(grain_count_q) > NW'(MAX_BINS)) begin
      n_bins = NW'(MAX_BINS);
    end else begin
      n_bins = NW'(grain_count_q);
    end
  end

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_fire    = in_i.valid & in_i.ready;
  assign op         = dsc_op_e'(in_i.operation);
  assign idx_ext    = NW'(in_i.bin_index);
  assign idx_ok     = idx_ext < n_bins;
  assign shift_one  = (shift_q == NW'(1));
  assign issue_diff = issue_q - shift_q;

  assign g_eff     = (grain_size_q == '0) ? GSIZE_W'(1) : grain_size_q;
  assign div_num   = DIV_NUM_W'({in_i.frequency, 1'b0}) + DIV_NUM_W'(g_eff);
  assign div_den   = {g_eff, 1'b0};
  assign div_start = in_fire && (op == OP_ADD);
  assign scl_start = (state_q == ST_READ) && rd_inrange_q && !sum_mode_q;

  // shared saturating adder for the bin sweep
  always_comb begin
    add_b     = fwd_q ? last_q : rdata_b;
    stg_sum   = {1'b0, rdata_a} + {1'b0, add_b};
    stg_sat   = stg_sum[VAL_W];
    stg_wdata = stg_sat ? VAL_MAX : stg_sum[VAL_W-1:0];
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = fill_q;
    mem_wdata = '0;
    raddr_a   = idx_ext[IdxW-1:0];
    raddr_b   = issue_diff[IdxW-1:0];
    unique case (state_q)
      ST_FILL: begin
        mem_we = 1'b1;
        if (fill_init_q && (NW'(fill_q) < n_bins) && (sum_mode_q || fill_q == '0)) begin
          mem_wdata = ONE_VALUE;
        end
      end
      ST_IDLE: begin
        if (in_fire && op == OP_LOAD && idx_ok) begin
          mem_we    = 1'b1;
          mem_waddr = idx_ext[IdxW-1:0];
          mem_wdata = in_i.load_value;
        end
      end
      ST_SWEEP: begin
        raddr_a = issue_q[IdxW-1:0];
        if (stg_v_q) begin
          mem_we    = 1'b1;
          mem_waddr = stg_idx_q;
          mem_wdata = stg_wdata;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_FILL;
      fill_q       <= '0;
      fill_init_q  <= 1'b0;
      ovf_flag_q   <= 1'b0;
      rd_inrange_q <= 1'b0;
      issue_q      <= '0;
      shift_q      <= '0;
      stg_v_q      <= 1'b0;
      fwd_q        <= 1'b0;
      stg_idx_q    <= '0;
      last_q       <= '0;
      res_q        <= '0;
      out_valid_q  <= 1'b0;
      out_ovf_q    <= 1'b0;
      out_count_q  <= '0;
    end else begin
      if (out_valid_q && out_o.ready && state_q != ST_PUSH) begin
        out_valid_q <= 1'b0;
      end
      if (stg_v_q) begin
        last_q <= stg_wdata;
        if (stg_sat) begin
          ovf_flag_q <= 1'b1;
        end
      end
      unique case (state_q)
        ST_FILL: begin
          if (fill_q == FILL_LAST) begin
            fill_q  <= '0;
            state_q <= ST_IDLE;
          end else begin
            fill_q <= fill_q + 1'b1;
          end
        end
        ST_IDLE: begin
          if (in_fire) begin
            unique case (op)
              OP_INIT: begin
                fill_init_q <= 1'b1;
                ovf_flag_q  <= 1'b0;
                state_q     <= ST_FILL;
              end
              OP_LOAD: ;
              OP_ADD:  state_q <= ST_DIV;
              OP_READ: begin
                rd_inrange_q <= idx_ok;
                state_q      <= ST_READ;
              end
              default: ;
            endcase
          end
        end
        ST_DIV: begin
          if (div_done) begin
            if (div_quo < DIV_NUM_W'(n_bins)) begin
              shift_q <= div_quo[NW-1:0];
              issue_q <= div_quo[NW-1:0];
              state_q <= ST_SWEEP;
            end else begin
              state_q <= ST_IDLE;
            end
          end
        end
        ST_SWEEP: begin
          if (issue_q < n_bins) begin
            issue_q   <= issue_q + 1'b1;
            stg_v_q   <= 1'b1;
            stg_idx_q <= issue_q[IdxW-1:0];
            fwd_q     <= shift_one && stg_v_q;
          end else begin
            stg_v_q <= 1'b0;
            fwd_q   <= 1'b0;
            if (!stg_v_q) begin
              state_q <= ST_IDLE;
            end
          end
        end
        ST_READ: begin
          if (!rd_inrange_q) begin
            res_q   <= '0;
            state_q <= ST_PUSH;
          end else if (sum_mode_q) begin
            res_q   <= rdata_a;
            state_q <= ST_PUSH;
          end else begin
            state_q <= ST_SCALE;
          end
        end
        ST_SCALE: begin
          if (scl_sts.done) begin
            res_q <= scl_result;
            if (scl_sts.sat) begin
              ovf_flag_q <= 1'b1;
            end
            state_q <= ST_PUSH;
          end
        end
        ST_PUSH: begin
          if (!out_valid_q || out_o.ready) begin
            out_valid_q <= 1'b1;
            out_count_q <= res_q;
            out_ovf_q   <= ovf_flag_q;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.count_value = out_count_q;
  assign out_o.overflowed  = out_ovf_q;

  dsc_table #(
    .Depth (MAX_BINS)
  ) u_table (
    .clk_i     (clk_i),
    .we_i      (mem_we),
    .waddr_i   (mem_waddr),
    .wdata_i   (mem_wdata),
    .raddr_a_i (raddr_a),
    .raddr_b_i (raddr_b),
    .rdata_a_o (rdata_a),
    .rdata_b_o (rdata_b)
  );

  dsc_divider u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .numer_i    (div_num),
    .denom_i    (div_den),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  dsc_scaler u_scaler (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (scl_start),
    .value_i  (rdata_a),
    .recip_i  (grain_recip_q),
    .sts_o    (scl_sts),
    .result_o (scl_result)
  );

  a_init_clears_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && op == OP_INIT) |=> !ovf_flag_q)
    else $error("overflow flag not cleared by initialise");

  a_sweep_in_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stg_v_q |-> ((NW'(stg_idx_q) >= shift_q) && (NW'(stg_idx_q) < n_bins)))
    else $error("sweep wrote a bin outside the shifted window");

  a_result_from_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_PUSH))
    else $error("result item raised outside the push step");

  a_idle_no_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.ready |-> !stg_v_q)
    else $error("ready while a bin update is still in flight");

endmodule
